// ===== rtl/core/crtess_pkg.sv =====
package crtess_pkg;

	localparam int MaxSegmentsDefault = 16;
	localparam int SegW = 5;
	localparam logic [SegW-1:0] SegReset = 5'd8;

	localparam int CoordW = 16;
	localparam int CoefW = 20;      // widest coefficient: 12 * 2^15
	localparam int TW = 17;         // Q1.16 parameter, 0 .. 65536
	localparam int ProdW = CoefW + TW + 1;
	localparam int AccW = 40;

	typedef struct packed {
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] x;
	} point_t;

	typedef struct packed {
		logic                     valid;
		logic                     last_step;
		logic [SegW-1:0]          step_index;
		logic signed [CoordW-1:0] curve_x;
		logic signed [CoordW-1:0] curve_y;
	} res_t;

	// floor(65536 / s) and 65536 mod s, s = 1..16
	function automatic logic [TW-1:0] recip_quot(input logic [SegW-1:0] s);
		logic [TW-1:0] q;
		unique case (s)
			5'd1:    q = 17'd65536;
			5'd2:    q = 17'd32768;
			5'd3:    q = 17'd21845;
			5'd4:    q = 17'd16384;
			5'd5:    q = 17'd13107;
			5'd6:    q = 17'd10922;
			5'd7:    q = 17'd9362;
			5'd8:    q = 17'd8192;
			5'd9:    q = 17'd7281;
			5'd10:   q = 17'd6553;
			5'd11:   q = 17'd5957;
			5'd12:   q = 17'd5461;
			5'd13:   q = 17'd5041;
			5'd14:   q = 17'd4681;
			5'd15:   q = 17'd4369;
			5'd16:   q = 17'd4096;
			default: q = 17'd0;
		endcase
		return q;
	endfunction

	function automatic logic [3:0] recip_rem(input logic [SegW-1:0] s);
		logic [3:0] r;
		unique case (s)
			5'd3:    r = 4'd1;
			5'd5:    r = 4'd1;
			5'd6:    r = 4'd4;
			5'd7:    r = 4'd2;
			5'd9:    r = 4'd7;
			5'd10:   r = 4'd6;
			5'd11:   r = 4'd9;
			5'd12:   r = 4'd4;
			5'd13:   r = 4'd3;
			5'd14:   r = 4'd2;
			5'd15:   r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/crtess_mac.sv =====
module crtess_mac (
	input  logic                                clk,
	input  logic signed [crtess_pkg::CoefW-1:0] op_a,
	input  logic        [crtess_pkg::TW-1:0]    op_b,
	output logic signed [crtess_pkg::ProdW-1:0] prod_s1
);
	import crtess_pkg::*;

	// single shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		prod_s1 <= ProdW'(op_a * $signed({1'b0, op_b}));
	end

endmodule

// ===== rtl/core/crtess_eval.sv =====
module crtess_eval (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  crtess_pkg::point_t              pts [4],
	input  logic [crtess_pkg::SegW-1:0]     seg_cnt,
	output crtess_pkg::res_t                res,
	input  logic                            res_ack,
	output logic                            span_done
);
	import crtess_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_STEP = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// multiply schedule for one curve point
	localparam logic [2:0] OP_TT  = 3'd0;
	localparam logic [2:0] OP_T2T = 3'd1;
	localparam logic [2:0] OP_AX  = 3'd2;
	localparam logic [2:0] OP_BX  = 3'd3;
	localparam logic [2:0] OP_CX  = 3'd4;
	localparam logic [2:0] OP_AY  = 3'd5;
	localparam logic [2:0] OP_BY  = 3'd6;
	localparam logic [2:0] OP_CY  = 3'd7;

	logic [2:0]               state_q;
	logic [2:0]               op_q;
	logic [SegW-1:0]          j_q;
	logic [SegW-1:0]          seg_q;
	logic [TW-1:0]            quot_q;
	logic [3:0]               rinc_q;
	logic [3:0]               rem_q;
	logic [TW-1:0]            t_q;
	logic [TW-1:0]            t2_q;
	logic [TW-1:0]            t3_q;
	logic signed [CoefW-1:0]  ca_x_q, cb_x_q, cc_x_q;
	logic signed [CoefW-1:0]  ca_y_q, cb_y_q, cc_y_q;
	logic signed [CoordW-1:0] p1x_q, p1y_q;
	logic signed [AccW-1:0]   acc_q;
	logic signed [CoordW-1:0] crv_x_q, crv_y_q;

	logic signed [CoefW-1:0]  op_a;
	logic [TW-1:0]            op_b;
	logic signed [ProdW-1:0]  prod_s1;
	logic signed [ProdW-1:0]  prod_rnd;
	logic [TW-1:0]            t_sq;
	logic signed [AccW-1:0]   acc_add;
	logic signed [AccW-1:0]   base_x, base_y;
	logic [SegW-1:0]          rem_sum;
	logic                     rem_wrap;
	logic                     last_step;

	function automatic logic signed [CoefW-1:0] sx(input logic signed [CoordW-1:0] v);
		return CoefW'(v);
	endfunction

	function automatic logic signed [CoefW-1:0] coef_a(input logic signed [CoordW-1:0] p0,
			input logic signed [CoordW-1:0] p2);
		return sx(p2) - sx(p0);
	endfunction

	function automatic logic signed [CoefW-1:0] coef_b(input logic signed [CoordW-1:0] p0,
			input logic signed [CoordW-1:0] p1, input logic signed [CoordW-1:0] p2,
			input logic signed [CoordW-1:0] p3);
		return (sx(p0) <<< 1) - (sx(p1) <<< 2) - sx(p1) + (sx(p2) <<< 2) - sx(p3);
	endfunction

	function automatic logic signed [CoefW-1:0] coef_c(input logic signed [CoordW-1:0] p0,
			input logic signed [CoordW-1:0] p1, input logic signed [CoordW-1:0] p2,
			input logic signed [CoordW-1:0] p3);
		return (sx(p1) <<< 1) + sx(p1) - sx(p0) - (sx(p2) <<< 1) - sx(p2) + sx(p3);
	endfunction

	// floor(acc / 2^17), clamped to the coordinate range
	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [AccW-1:0] a);
		logic signed [AccW-1:0] sh;
		logic signed [CoordW-1:0] r;
		sh = a >>> 17;
		if (sh > AccW'(32767))
			r = 16'sh7FFF;
		else if (sh < -AccW'(32768))
			r = 16'sh8000;
		else
			r = sh[CoordW-1:0];
		return r;
	endfunction

	always_comb begin
		unique case (op_q)
			OP_TT:   begin op_a = CoefW'(t_q);  op_b = t_q;  end
			OP_T2T:  begin op_a = CoefW'(t2_q); op_b = t_q;  end
			OP_AX:   begin op_a = ca_x_q;       op_b = t_q;  end
			OP_BX:   begin op_a = cb_x_q;       op_b = t2_q; end
			OP_CX:   begin op_a = cc_x_q;       op_b = t3_q; end
			OP_AY:   begin op_a = ca_y_q;       op_b = t_q;  end
			OP_BY:   begin op_a = cb_y_q;       op_b = t2_q; end
			default: begin op_a = cc_y_q;       op_b = t3_q; end
		endcase
	end

	crtess_mac u_mac (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	assign prod_rnd = prod_s1 + ProdW'(32768);
	assign t_sq     = prod_rnd[32:16];
	assign acc_add  = acc_q + AccW'(prod_s1);
	// 2*p1*2^16 plus the rounding half
	assign base_x   = (AccW'(p1x_q) <<< 17) + AccW'(65536) + AccW'(prod_s1);
	assign base_y   = (AccW'(p1y_q) <<< 17) + AccW'(65536) + AccW'(prod_s1);

	// t = floor((j*65536 + S/2) / S), stepped by quotient and remainder
	assign rem_sum  = {1'b0, rem_q} + {1'b0, rinc_q};
	assign rem_wrap = (rem_sum >= seg_q);

	assign last_step = (j_q == seg_q);

	always_comb begin
		res.valid      = (state_q == ST_OUT);
		res.last_step  = last_step;
		res.step_index = j_q;
		res.curve_x    = crv_x_q;
		res.curve_y    = crv_y_q;
	end

	assign span_done = (state_q == ST_OUT) && res_ack && last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_STEP;
				ST_STEP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC:  state_q <= (op_q == OP_CY) ? ST_FIN : ST_MUL;
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (res_ack) state_q <= last_step ? ST_IDLE : ST_STEP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					seg_q  <= seg_cnt;
					quot_q <= recip_quot(seg_cnt);
					rinc_q <= recip_rem(seg_cnt);
					rem_q  <= 4'(seg_cnt >> 1);
					t_q    <= '0;
					j_q    <= '0;
					p1x_q  <= pts[1].x;
					p1y_q  <= pts[1].y;
					ca_x_q <= coef_a(pts[0].x, pts[2].x);
					cb_x_q <= coef_b(pts[0].x, pts[1].x, pts[2].x, pts[3].x);
					cc_x_q <= coef_c(pts[0].x, pts[1].x, pts[2].x, pts[3].x);
					ca_y_q <= coef_a(pts[0].y, pts[2].y);
					cb_y_q <= coef_b(pts[0].y, pts[1].y, pts[2].y, pts[3].y);
					cc_y_q <= coef_c(pts[0].y, pts[1].y, pts[2].y, pts[3].y);
				end
			end
			ST_STEP: begin
				t_q   <= t_q + quot_q + TW'(rem_wrap);
				rem_q <= rem_wrap ? 4'(rem_sum - seg_q) : rem_sum[3:0];
				j_q   <= j_q + 5'd1;
				op_q  <= OP_TT;
			end
			ST_ACC: begin
				unique case (op_q)
					OP_TT:  t2_q  <= t_sq;
					OP_T2T: t3_q  <= t_sq;
					OP_AX:  acc_q <= base_x;
					OP_AY: begin
						crv_x_q <= sat_coord(acc_q);
						acc_q   <= base_y;
					end
					default: acc_q <= acc_add;
				endcase
				op_q <= op_q + 3'd1;
			end
			ST_FIN: crv_y_q <= sat_coord(acc_q);
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/catmull_rom_ring_tessellator.sv =====
// Closed-ring uniform Catmull-Rom tessellator. Control points (signed Q11.4)
// arrive one item at a time, the final point of a ring flagged by last_point.
// Once four points of a ring are known, each new point yields the span that
// starts two points back; the last point also flushes the three wrap-around
// spans, the span starting at the ring's first point coming out last. Each
// span gives segments_per_span curve points at t = j/S, j = 1..S, tagged with
// the span's anchor point and step_index j; final_result marks the last
// result of an item. A ring of fewer than four points gives no results.
// segments_per_span reads 0 as 1 and clamps above MAX_SEGMENTS; write it only
// while the block is idle. Every curve point is computed on a single
// shared 20x18 multiplier: eight products, each one multiplied and then
// accumulated, plus a t step and a finish step; the evaluator starts the
// next curve point only once the output register has taken the last. An
// item that makes spans makes 1 or 4 of them, and in_ready is low while
// they are being evaluated; an item that makes none leaves in_ready high.
module catmull_rom_ring_tessellator #(
	parameter int MAX_SEGMENTS = crtess_pkg::MaxSegmentsDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [crtess_pkg::SegW-1:0]      cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [crtess_pkg::CoordW-1:0] point_x,
	input  logic signed [crtess_pkg::CoordW-1:0] point_y,
	input  logic                             last_point,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [crtess_pkg::CoordW-1:0] anchor_x,
	output logic signed [crtess_pkg::CoordW-1:0] anchor_y,
	output logic signed [crtess_pkg::CoordW-1:0] curve_x,
	output logic signed [crtess_pkg::CoordW-1:0] curve_y,
	output logic [crtess_pkg::SegW-1:0]      step_index,
	output logic                             final_result
);
	import crtess_pkg::*;

	// segments register
	logic [SegW-1:0] seg_cfg_q;
	logic [SegW-1:0] seg_eff;

	// ring state
	point_t      head_q   [3];
	point_t      recent_q [3];
	logic [2:0]  seen_q;        // saturates at 4

	// job: window of seven points, span k uses entries k..k+3;
	// the window shifts down one entry per finished span
	point_t      win_q    [7];
	point_t      span_pts [4];
	logic [1:0]  spans_left_q;
	logic        busy_q;
	logic        start_q;

	point_t      pt;
	logic        in_acc;
	logic        has_span;

	res_t        res;
	logic        res_ack;
	logic        span_done;

	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cfg_q <= SegReset;
		end else if (cfg_wr_en) begin
			seg_cfg_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (seg_cfg_q == '0)
			seg_eff = SegW'(1);
		else if (seg_cfg_q > SegW'(MAX_SEGMENTS))
			seg_eff = SegW'(MAX_SEGMENTS);
		else
			seg_eff = seg_cfg_q;
	end

	assign pt       = '{y: point_y, x: point_x};
	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;
	// a span over the three kept points and the new one exists from the fourth point on
	assign has_span = (seen_q >= 3'd3);

	// ring bookkeeping; the last point clears everything for the next ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				head_q[i]   <= '0;
				recent_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (in_acc) begin
			if (last_point) begin
				for (int i = 0; i < 3; i++) begin
					head_q[i]   <= '0;
					recent_q[i] <= '0;
				end
				seen_q <= '0;
			end else begin
				if (seen_q < 3'd3) head_q[seen_q[1:0]] <= pt;
				recent_q[0] <= recent_q[1];
				recent_q[1] <= recent_q[2];
				recent_q[2] <= pt;
				if (seen_q < 3'd4) seen_q <= seen_q + 3'd1;
			end
		end
	end

	// job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			start_q      <= 1'b0;
			spans_left_q <= '0;
		end else begin
			start_q <= 1'b0;
			if (in_acc && has_span) begin
				busy_q       <= 1'b1;
				start_q      <= 1'b1;
				spans_left_q <= last_point ? 2'd3 : 2'd0;
			end else if (span_done) begin
				if (spans_left_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					spans_left_q <= spans_left_q - 2'd1;
					start_q      <= 1'b1;
				end
			end
		end
	end

	// window: old recent, new recent, then the head points for the flush
	always_ff @(posedge clk) begin
		if (in_acc && has_span) begin
			win_q[0] <= recent_q[0];
			win_q[1] <= recent_q[1];
			win_q[2] <= recent_q[2];
			win_q[3] <= pt;
			win_q[4] <= head_q[0];
			win_q[5] <= head_q[1];
			win_q[6] <= head_q[2];
		end else if (span_done) begin
			for (int i = 0; i < 6; i++) win_q[i] <= win_q[i+1];
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) span_pts[i] = win_q[i];
	end

	crtess_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.pts       (span_pts),
		.seg_cnt   (seg_eff),
		.res       (res),
		.res_ack   (res_ack),
		.span_done (span_done)
	);

	// output register decouples the evaluator from the consumer
	assign res_ack = res.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			anchor_x     <= win_q[1].x;
			anchor_y     <= win_q[1].y;
			curve_x      <= res.curve_x;
			curve_y      <= res.curve_y;
			step_index   <= res.step_index;
			final_result <= res.last_step && (spans_left_q == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/tb_catmull_rom_ring_tessellator.sv =====
`timescale 1ns / 1ps

module tb_catmull_rom_ring_tessellator;
	import crtess_pkg::*;

	localparam int RandomItems  = 110;
	localparam int CycleLimit   = 1000000;
	// Cycles allowed after the last curve point before a register write or the
	// end; an item that makes no span is taken while in_ready stays high.
	localparam int SettleCycles = 40;
	// Long receiver hold-off, long enough to back the block up into its input.
	localparam int HoldCycles   = 600;

	// One curve point as it leaves the block.
	typedef struct packed {
		logic signed [CoordW-1:0] anchor_x;
		logic signed [CoordW-1:0] anchor_y;
		logic signed [CoordW-1:0] curve_x;
		logic signed [CoordW-1:0] curve_y;
		logic [SegW-1:0]          step_index;
		logic                     final_result;
	} curve_pt_t;

	// Ring tracker and curve point predictor. It mirrors the block's state:
	// first three points of the ring, a window of the latest three and a
	// count that saturates at four.
	class ring_scoreboard;
		point_t          head_pts[3];
		point_t          window[3];
		int unsigned     seen;
		logic [SegW-1:0] seg_reg;
		curve_pt_t       curve_q[$];
		int unsigned     faults;

		function new();
			clear_ring();
			seg_reg = SegReset;
			faults  = 0;
		endfunction

		function void clear_ring();
			foreach (head_pts[i]) begin
				head_pts[i] = '0;
				window[i]   = '0;
			end
			seen = 0;
		endfunction

		function void set_segments(logic [SegW-1:0] v);
			seg_reg = v;
		endfunction

		function int unsigned pending();
			return curve_q.size();
		endfunction

		// zero reads as one, anything past the maximum clamps
		function int unsigned span_steps();
			int unsigned s;
			s = seg_reg;
			if (s == 0)
				s = 1;
			if (s > MaxSegmentsDefault)
				s = MaxSegmentsDefault;
			return s;
		endfunction

		// Catmull-Rom blend of one coordinate, t terms in Q1.16, result
		// rounded half up and saturated to Q11.4 range.
		function logic signed [CoordW-1:0] blend(longint p0, longint p1, longint p2,
				longint p3, longint t, longint t2, longint t3);
			longint a, b, c, acc, r;
			a   = p2 - p0;
			b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
			c   = -p0 + 3 * p1 - 3 * p2 + p3;
			acc = 2 * p1 * 65536 + a * t + b * t2 + c * t3;
			r   = (acc + 65536) >>> 17;
			if (r > 32767)
				r = 32767;
			else if (r < -32768)
				r = -32768;
			return r[CoordW-1:0];
		endfunction

		// Queue the curve points of the span from q1 to q2.
		function void emit_span(point_t q0, point_t q1, point_t q2, point_t q3);
			int unsigned s, j;
			longint      t, t2, t3;
			curve_pt_t   cp;
			s = span_steps();
			for (j = 1; j <= s; j++) begin
				t  = (longint'(j) * 65536 + longint'(s / 2)) / longint'(s);
				t2 = (t * t + 32768) / 65536;
				t3 = (t2 * t + 32768) / 65536;
				cp.anchor_x     = q1.x;
				cp.anchor_y     = q1.y;
				cp.curve_x      = blend(longint'(q0.x), longint'(q1.x), longint'(q2.x),
						longint'(q3.x), t, t2, t3);
				cp.curve_y      = blend(longint'(q0.y), longint'(q1.y), longint'(q2.y),
						longint'(q3.y), t, t2, t3);
				cp.step_index   = j[SegW-1:0];
				cp.final_result = 1'b0;
				curve_q = {curve_q, cp};
			end
		endfunction

		function void note_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
				logic lp);
			point_t      pt;
			int unsigned prior_n;
			pt.x    = x;
			pt.y    = y;
			prior_n = curve_q.size();
			if (seen < 3)
				head_pts[seen] = pt;
			else
				emit_span(window[0], window[1], window[2], pt);
			window[0] = window[1];
			window[1] = window[2];
			window[2] = pt;
			if (seen < 4)
				seen++;
			if (lp) begin
				// wrap-around spans; the one anchored at the first point goes last
				if (seen >= 4) begin
					emit_span(window[0], window[1], window[2], head_pts[0]);
					emit_span(window[1], window[2], head_pts[0], head_pts[1]);
					emit_span(window[2], head_pts[0], head_pts[1], head_pts[2]);
				end
				clear_ring();
			end
			if (curve_q.size() > prior_n)
				curve_q[curve_q.size() - 1].final_result = 1'b1;
		endfunction

		function void check_result(curve_pt_t got);
			curve_pt_t want;
			bit        bad;
			if (curve_q.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("[%0t] curve point with none pending: x=%0d y=%0d j=%0d",
							$time, got.curve_x, got.curve_y, got.step_index);
				return;
			end
			want = curve_q.pop_front();
			bad  = (got.anchor_x !== want.anchor_x) || (got.anchor_y !== want.anchor_y) ||
					(got.curve_x !== want.curve_x) || (got.curve_y !== want.curve_y) ||
					(got.step_index !== want.step_index) ||
					(got.final_result !== want.final_result);
			if (bad) begin
				faults++;
				if (faults <= 10) begin
					$display("[%0t] curve point mismatch", $time);
					$display("  exp anchor=(%0d,%0d) curve=(%0d,%0d) j=%0d final=%0b",
							want.anchor_x, want.anchor_y, want.curve_x, want.curve_y,
							want.step_index, want.final_result);
					$display("  got anchor=(%0d,%0d) curve=(%0d,%0d) j=%0d final=%0b",
							got.anchor_x, got.anchor_y, got.curve_x, got.curve_y,
							got.step_index, got.final_result);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [SegW-1:0]          cfg_wr_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [CoordW-1:0] point_x;
	logic signed [CoordW-1:0] point_y;
	logic                     last_point;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [CoordW-1:0] anchor_x;
	logic signed [CoordW-1:0] anchor_y;
	logic signed [CoordW-1:0] curve_x;
	logic signed [CoordW-1:0] curve_y;
	logic [SegW-1:0]          step_index;
	logic                     final_result;

	// calm: no idling on either side; hold_go: one long receiver hold-off
	logic calm;
	logic hold_go;

	ring_scoreboard ring_sb;

	catmull_rom_ring_tessellator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.anchor_x     (anchor_x),
		.anchor_y     (anchor_y),
		.curve_x      (curve_x),
		.curve_y      (curve_y),
		.step_index   (step_index),
		.final_result (final_result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Random coordinate: rails, full range, or small values near the origin.
	function automatic logic signed [CoordW-1:0] pick_coord();
		int v;
		case ($urandom_range(9))
			0: v = 32767;
			1: v = -32768;
			2, 3, 4: v = int'($urandom_range(65535)) - 32768;
			default: v = int'($urandom_range(4000)) - 2000;
		endcase
		return v[CoordW-1:0];
	endfunction

	// Offer one control point; valid stays up until the item is taken.
	// Handshake signals are sampled right at the edge, before any update.
	task automatic send_point(input logic signed [CoordW-1:0] x,
			input logic signed [CoordW-1:0] y, input logic lp);
		while (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		point_x    <= x;
		point_y    <= y;
		last_point <= lp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ring_sb.note_point(x, y, lp);
	endtask

	// Stop offering, wait for every pending curve point, then let the block
	// run out whatever it may still be finishing.
	task automatic settle();
		in_valid <= 1'b0;
		while (ring_sb.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_segments(input logic [SegW-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ring_sb.set_segments(v);
	endtask

	// Result side: check what was taken at this edge, then choose out_ready
	// for the next cycle. Owns out_ready alone.
	initial begin : result_sink
		int unsigned hold_left;
		bit          held;
		curve_pt_t   got;
		hold_left = 0;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {anchor_x, anchor_y, curve_x, curve_y, step_index, final_result};
				ring_sb.check_result(got);
			end
			if (hold_go && !held) begin
				hold_left = HoldCycles;
				held      = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	initial begin : stimulus
		int unsigned     sent, phase, phase_items, ring_len, k;
		logic [SegW-1:0] seg_pick;
		ring_sb     = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		point_x     = '0;
		point_y     = '0;
		last_point  = 1'b0;
		calm        = 1'b0;
		hold_go     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, segment count still at its reset value ---
		// short ring of three points: no curve
		send_point(16'sd100, -16'sd50, 1'b0);
		send_point(-16'sd300, 16'sd20, 1'b0);
		send_point(16'sd0, 16'sd700, 1'b1);
		// lone point that is also the last one
		send_point(16'sd5, 16'sd5, 1'b1);
		// four points on the rails: every span saturates somewhere
		send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_point(16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sh7FFF, 16'sh8000, 1'b0);
		send_point(16'sh8000, 16'sh7FFF, 1'b1);
		settle();

		// zero in the register reads as one step per span; long ring so the
		// count saturates and head points stop updating
		write_segments('0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd160, 16'sd0, 1'b0);
		send_point(16'sd160, 16'sd160, 1'b0);
		send_point(16'sd0, 16'sd160, 1'b0);
		send_point(-16'sd160, 16'sd80, 1'b0);
		send_point(-16'sd1, -16'sd1, 1'b0);
		send_point(16'sd80, -16'sd160, 1'b1);
		settle();

		// all ones clamps to the maximum: four spans of sixteen points
		write_segments(5'd31);
		send_point(16'sd1000, -16'sd2000, 1'b0);
		send_point(-16'sd12000, 16'sd9000, 1'b0);
		send_point(16'sd20000, 16'sd15000, 1'b0);
		send_point(-16'sd7, 16'sd30000, 1'b1);

		// --- random part: phases of whole rings, one register setting each ---
		sent  = 0;
		phase = 0;
		while (sent < RandomItems) begin
			settle();
			case ($urandom_range(9))
				0: seg_pick = '0;
				1: seg_pick = 5'd16;
				2: seg_pick = 5'($urandom_range(31, 17));
				default: seg_pick = 5'($urandom_range(6, 1));
			endcase
			write_segments(seg_pick);
			// first phase: receiver backs off while points keep coming
			if (phase == 0)
				hold_go <= 1'b1;
			// third phase runs flat out on both sides
			calm <= (phase == 2);
			phase_items = 0;
			while (phase_items < 24 && sent < RandomItems) begin
				// mostly full rings; now and then a short one that gives nothing
				if ($urandom_range(4) == 0)
					ring_len = $urandom_range(3, 1);
				else
					ring_len = $urandom_range(9, 4);
				for (k = 1; k <= ring_len; k++)
					send_point(pick_coord(), pick_coord(), k == ring_len);
				sent        += ring_len;
				phase_items += ring_len;
			end
			phase++;
		end

		settle();
		if (ring_sb.faults == 0 && ring_sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		repeat (CycleLimit) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
